// File: design/tlps_pkg.sv
// ----------------------------------------------------------------------------
// tlps_pkg
// Shared types, register indexes and helpers for the tank level pump starter.
// ----------------------------------------------------------------------------
`default_nettype none

package tlps_pkg;

    // accepted tank level codes
    typedef enum logic [1:0] {
        LVL_HIGH    = 2'd0,
        LVL_LOW     = 2'd1,
        LVL_MID     = 2'd2,
        LVL_UNKNOWN = 2'd3
    } level_t;

    // configuration register indexes
    localparam logic [7:0] CFG_DEBOUNCE_TICKS = 8'd0;
    localparam logic [7:0] CFG_START_TICKS    = 8'd1;

    // configuration reset values
    localparam logic [7:0] DEBOUNCE_TICKS_RST = 8'd3;
    localparam logic [7:0] START_TICKS_RST    = 8'd5;

    // widest timer supported
    localparam int TIMER_MAX_BITS = 16;

    // coil drive pair from the motor control
    typedef struct packed {
        logic start_coil;
        logic run_coil;
    } coil_t;

    // timer load: saturate to the timer range, zero acts as one
    function automatic logic [TIMER_MAX_BITS-1:0] timer_load(
        input logic [7:0]                v,
        input logic [TIMER_MAX_BITS-1:0] maxv
    );
        logic [TIMER_MAX_BITS-1:0] ext;
        ext = {{(TIMER_MAX_BITS-8){1'b0}}, v};
        if (ext > maxv)
        begin
            ext = maxv;
        end
        if (ext == '0)
        begin
            ext = {{(TIMER_MAX_BITS-1){1'b0}}, 1'b1};
        end
        return ext;
    endfunction

endpackage

`default_nettype wire

// File: design/tank_level_pump_starter.sv
// A beat accepted into the input register is shown from the result register behind it.
// Throughput: one beat per cycle; the input register and the result register
// move together, so the input stalls only while a held result is stalled.
// Reset: asynchronous, active low; levels unknown, motor off, debounce 3,
// start 5 ticks.
// ----------------------------------------------------------------------------
// tank_level_pump_starter
// Debounced sump and overhead tank levels driving a two-coil pump starter.
// ----------------------------------------------------------------------------
`default_nettype none

module tank_level_pump_starter #(
    parameter int TIMER_BITS = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    // sensor beats
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       tank_high_wet,
    input  wire logic       tank_low_wet,
    input  wire logic       sump_high_wet,
    input  wire logic       sump_low_wet,
    // result beats
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            start_coil,
    output logic            run_coil,
    output logic [1:0]      sump_level,
    output logic [1:0]      tank_level
);

    localparam logic [tlps_pkg::TIMER_MAX_BITS-1:0] TIMER_MAX =
        tlps_pkg::TIMER_MAX_BITS'((32'd1 << TIMER_BITS) - 32'd1);

    logic [7:0]            dbnc_cfg_reg;
    logic [7:0]            start_cfg_reg;
    logic [tlps_pkg::TIMER_MAX_BITS-1:0] dbnc_load_wide;
    logic [tlps_pkg::TIMER_MAX_BITS-1:0] start_load_wide;
    logic [TIMER_BITS-1:0] dbnc_load;
    logic [TIMER_BITS-1:0] start_load;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_tank_high_reg;
    logic                  s1_tank_low_reg;
    logic                  s1_sump_high_reg;
    logic                  s1_sump_low_reg;
    logic                  in_accept;
    logic                  adv;

    logic                  starting;
    tlps_pkg::level_t      sump_lvl_next;
    tlps_pkg::level_t      tank_lvl_next;
    tlps_pkg::coil_t       coil_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    tlps_pkg::coil_t       out_coil_reg;
    tlps_pkg::level_t      out_sump_reg;
    tlps_pkg::level_t      out_tank_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbnc_cfg_reg  <= tlps_pkg::DEBOUNCE_TICKS_RST;
            start_cfg_reg <= tlps_pkg::START_TICKS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tlps_pkg::CFG_DEBOUNCE_TICKS)
            begin
                dbnc_cfg_reg <= cfg_data;
            end
            else if (cfg_index == tlps_pkg::CFG_START_TICKS)
            begin
                start_cfg_reg <= cfg_data;
            end
        end
    end

    // timer load values
    assign dbnc_load_wide  = tlps_pkg::timer_load(dbnc_cfg_reg, TIMER_MAX);
    assign start_load_wide = tlps_pkg::timer_load(start_cfg_reg, TIMER_MAX);
    assign dbnc_load       = dbnc_load_wide[TIMER_BITS-1:0];
    assign start_load      = start_load_wide[TIMER_BITS-1:0];

    // handshake: the input register moves whenever the result register can take it
    assign adv       = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_tank_high_reg <= tank_high_wet;
            s1_tank_low_reg  <= tank_low_wet;
            s1_sump_high_reg <= sump_high_wet;
            s1_sump_low_reg  <= sump_low_wet;
        end
    end

    // level debounce, frozen during the start phase
    tlps_debounce #(
        .TIMER_BITS (TIMER_BITS)
    ) u_sump_dbnc (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv && !starting),
        .high_wet   (s1_sump_high_reg),
        .low_wet    (s1_sump_low_reg),
        .load_val   (dbnc_load),
        .level_next (sump_lvl_next)
    );

    tlps_debounce #(
        .TIMER_BITS (TIMER_BITS)
    ) u_tank_dbnc (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv && !starting),
        .high_wet   (s1_tank_high_reg),
        .low_wet    (s1_tank_low_reg),
        .load_val   (dbnc_load),
        .level_next (tank_lvl_next)
    );

    // motor control
    tlps_motor #(
        .TIMER_BITS (TIMER_BITS)
    ) u_motor (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .sump_lvl   (sump_lvl_next),
        .tank_lvl   (tank_lvl_next),
        .start_load (start_load),
        .starting   (starting),
        .coil_next  (coil_next)
    );

    // result register payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_coil_reg <= coil_next;
            out_sump_reg <= sump_lvl_next;
            out_tank_reg <= tank_lvl_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign start_coil = out_coil_reg.start_coil;
    assign run_coil   = out_coil_reg.run_coil;
    assign sump_level = out_sump_reg;
    assign tank_level = out_tank_reg;

    // the start coil never drives without the run coil
    a_start_with_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!start_coil || run_coil))
        else $error("start coil without run coil");

    // a start is never shown while either level is unknown
    a_start_known_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && start_coil) |->
            ((sump_level != tlps_pkg::LVL_UNKNOWN) && (tank_level != tlps_pkg::LVL_UNKNOWN)))
        else $error("start with unknown level");

    // input backpressure only while a held result is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output stall");

    // a result beat follows every advancing input beat
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid)
        else $error("result beat lost");

endmodule

`default_nettype wire

// File: design/tlps_debounce.sv
// ----------------------------------------------------------------------------
// tlps_debounce
// Level classifier and two-sample debounce for one tank.
// ----------------------------------------------------------------------------
`default_nettype none

module tlps_debounce #(
    parameter int TIMER_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  high_wet,
    input  wire logic                  low_wet,
    input  wire logic [TIMER_BITS-1:0] load_val,
    output tlps_pkg::level_t           level_next
);

    tlps_pkg::level_t        raw;
    tlps_pkg::level_t        acc_reg;
    tlps_pkg::level_t        acc_next;
    tlps_pkg::level_t        pend_reg;
    tlps_pkg::level_t        pend_next;
    logic [TIMER_BITS-1:0]   wait_reg;
    logic [TIMER_BITS-1:0]   wait_next;

    // raw class, low sensor dry wins
    always_comb
    begin
        if (!low_wet)
        begin
            raw = tlps_pkg::LVL_LOW;
        end
        else if (high_wet)
        begin
            raw = tlps_pkg::LVL_HIGH;
        end
        else
        begin
            raw = tlps_pkg::LVL_MID;
        end
    end

    // pending class, wait count and confirming sample
    always_comb
    begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        wait_next = wait_reg;
        if (en)
        begin
            if (wait_reg == '0)
            begin
                if (raw != acc_reg)
                begin
                    pend_next = raw;
                    wait_next = load_val;
                end
            end
            else
            begin
                wait_next = wait_reg - 1'b1;
                if ((wait_next == '0) && (raw == pend_reg))
                begin
                    acc_next = raw;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= tlps_pkg::LVL_UNKNOWN;
            pend_reg <= tlps_pkg::LVL_HIGH;
            wait_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            wait_reg <= wait_next;
        end
    end

    assign level_next = acc_next;

endmodule

`default_nettype wire

// File: design/tlps_motor.sv
// ----------------------------------------------------------------------------
// tlps_motor
// Motor start and stop control with the start phase timer.
// ----------------------------------------------------------------------------
`default_nettype none

module tlps_motor #(
    parameter int TIMER_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire tlps_pkg::level_t      sump_lvl,
    input  wire tlps_pkg::level_t      tank_lvl,
    input  wire logic [TIMER_BITS-1:0] start_load,
    output logic                       starting,
    output tlps_pkg::coil_t            coil_next
);

    logic [TIMER_BITS-1:0] remain_reg;
    logic [TIMER_BITS-1:0] remain_next;
    logic                  run_reg;
    logic                  run_next;
    logic                  start_out;

    assign starting = (remain_reg != '0);

    // start phase countdown, then stop and start decisions
    always_comb
    begin
        remain_next = remain_reg;
        run_next    = run_reg;
        start_out   = 1'b0;
        if (en)
        begin
            if (starting)
            begin
                remain_next = remain_reg - 1'b1;
                if (remain_next == '0)
                begin
                    run_next = 1'b1;
                end
                else
                begin
                    start_out = 1'b1;
                end
            end
            else if ((sump_lvl == tlps_pkg::LVL_LOW) || (sump_lvl == tlps_pkg::LVL_UNKNOWN) ||
                     (tank_lvl == tlps_pkg::LVL_HIGH) || (tank_lvl == tlps_pkg::LVL_UNKNOWN))
            begin
                run_next = 1'b0;
            end
            else if ((tank_lvl == tlps_pkg::LVL_LOW) && !run_reg)
            begin
                remain_next = start_load;
                start_out   = 1'b1;
            end
        end
    end

    assign coil_next.start_coil = start_out;
    assign coil_next.run_coil   = start_out | run_next;

    // motor state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            run_reg    <= 1'b0;
        end
        else
        begin
            remain_reg <= remain_next;
            run_reg    <= run_next;
        end
    end

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tank level pump starter: sensor beats are
// pushed through a randomly idling driver, a beat-by-beat pump model predicts
// every result beat, and a randomly stalling monitor compares each field.
// ----------------------------------------------------------------------------

module tb;

    // unused register indexes, writes there must be ignored
    localparam logic [7:0] CFG_SPARE_LO = 8'd2;
    localparam logic [7:0] CFG_SPARE_HI = 8'hFF;

    localparam int SUMP        = 0;
    localparam int TANK        = 1;
    localparam int IDLE_PCT    = 27;
    localparam int CYCLE_LIMIT = 400000;

    // one sensor beat, tank high sensor in the msb
    typedef struct packed {
        logic tank_hi;
        logic tank_lo;
        logic sump_hi;
        logic sump_lo;
    } sensors_t;

    // one result beat
    typedef struct packed {
        logic             start_coil;
        logic             run_coil;
        tlps_pkg::level_t sump_level;
        tlps_pkg::level_t tank_level;
    } reading_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       cfg_we        = 1'b0;
    logic [7:0] cfg_index     = 8'd0;
    logic [7:0] cfg_data      = 8'd0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic       tank_high_wet = 1'b0;
    logic       tank_low_wet  = 1'b0;
    logic       sump_high_wet = 1'b0;
    logic       sump_low_wet  = 1'b0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic       start_coil;
    logic       run_coil;
    logic [1:0] sump_level;
    logic [1:0] tank_level;

    // no idling on either side while set
    logic       calm          = 1'b0;
    int         fail_count    = 0;
    int         cycle_count   = 0;

    sensors_t   sensor_q[$];
    reading_t   reading_q[$];
    sensors_t   next_beat;
    reading_t   got_reading;
    reading_t   want_reading;

    // pump model state and its copy of the registers
    tlps_pkg::level_t acc_lvl[2];
    tlps_pkg::level_t pend_lvl[2];
    logic [7:0] hold_cnt[2];
    logic       motor_on;
    logic [7:0] start_left;
    logic [7:0] deb_cfg;
    logic [7:0] start_cfg;

    tank_level_pump_starter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .tank_high_wet (tank_high_wet),
        .tank_low_wet  (tank_low_wet),
        .sump_high_wet (sump_high_wet),
        .sump_low_wet  (sump_low_wet),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .start_coil    (start_coil),
        .run_coil      (run_coil),
        .sump_level    (sump_level),
        .tank_level    (tank_level)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // raw class: a dry low sensor wins over a wet high sensor
    function automatic tlps_pkg::level_t classify_level(input logic high_wet,
                                                        input logic low_wet);
        if (!low_wet)
        begin
            return tlps_pkg::LVL_LOW;
        end
        if (high_wet)
        begin
            return tlps_pkg::LVL_HIGH;
        end
        return tlps_pkg::LVL_MID;
    endfunction

    // timer load, zero acts as one; an 8-bit register never exceeds the 8-bit timer
    function automatic logic [7:0] count_load(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    // two-sample debounce of one tank
    function automatic void settle_level(input int t, input tlps_pkg::level_t raw);
        if (hold_cnt[t] == 8'd0)
        begin
            if (raw != acc_lvl[t])
            begin
                pend_lvl[t] = raw;
                hold_cnt[t] = count_load(deb_cfg);
            end
        end
        else
        begin
            hold_cnt[t] = hold_cnt[t] - 8'd1;
            if (hold_cnt[t] == 8'd0 && raw == pend_lvl[t])
            begin
                acc_lvl[t] = raw;
            end
        end
    endfunction

    // one tick of the pump controller
    function automatic reading_t pump_step(input sensors_t s);
        reading_t r;
        logic     starting;
        starting = 1'b0;
        if (start_left != 8'd0)
        begin
            // start phase: sensors ignored, levels frozen
            start_left = start_left - 8'd1;
            if (start_left == 8'd0)
            begin
                motor_on = 1'b1;
            end
            else
            begin
                starting = 1'b1;
            end
        end
        else
        begin
            settle_level(SUMP, classify_level(s.sump_hi, s.sump_lo));
            settle_level(TANK, classify_level(s.tank_hi, s.tank_lo));
            if (acc_lvl[SUMP] == tlps_pkg::LVL_LOW || acc_lvl[SUMP] == tlps_pkg::LVL_UNKNOWN ||
                acc_lvl[TANK] == tlps_pkg::LVL_HIGH || acc_lvl[TANK] == tlps_pkg::LVL_UNKNOWN)
            begin
                motor_on = 1'b0;
            end
            else if (acc_lvl[TANK] == tlps_pkg::LVL_LOW && !motor_on)
            begin
                start_left = count_load(start_cfg);
                starting   = 1'b1;
            end
        end
        r.start_coil = starting;
        r.run_coil   = starting | motor_on;
        r.sump_level = acc_lvl[SUMP];
        r.tank_level = acc_lvl[TANK];
        return r;
    endfunction

    task automatic model_reset();
        acc_lvl[SUMP]  = tlps_pkg::LVL_UNKNOWN;
        acc_lvl[TANK]  = tlps_pkg::LVL_UNKNOWN;
        pend_lvl[SUMP] = tlps_pkg::LVL_HIGH;
        pend_lvl[TANK] = tlps_pkg::LVL_HIGH;
        hold_cnt[SUMP] = 8'd0;
        hold_cnt[TANK] = 8'd0;
        motor_on       = 1'b0;
        start_left     = 8'd0;
        deb_cfg        = tlps_pkg::DEBOUNCE_TICKS_RST;
        start_cfg      = tlps_pkg::START_TICKS_RST;
    endtask

    // sensor pattern for a pair of classes; a low sump or tank sometimes shows a wet high sensor
    function automatic sensors_t sensors_for(input tlps_pkg::level_t sump_cls,
                                             input tlps_pkg::level_t tank_cls);
        sensors_t s;
        s.sump_lo = (sump_cls != tlps_pkg::LVL_LOW);
        s.sump_hi = (sump_cls == tlps_pkg::LVL_HIGH) ||
                    (sump_cls == tlps_pkg::LVL_LOW && $urandom_range(3) == 0);
        s.tank_lo = (tank_cls != tlps_pkg::LVL_LOW);
        s.tank_hi = (tank_cls == tlps_pkg::LVL_HIGH) ||
                    (tank_cls == tlps_pkg::LVL_LOW && $urandom_range(3) == 0);
        return s;
    endfunction

    function automatic tlps_pkg::level_t pick_tank();
        int p;
        p = $urandom_range(99);
        return (p < 40) ? tlps_pkg::LVL_LOW : (p < 70) ? tlps_pkg::LVL_MID : tlps_pkg::LVL_HIGH;
    endfunction

    function automatic tlps_pkg::level_t pick_sump();
        int p;
        p = $urandom_range(99);
        return (p < 45) ? tlps_pkg::LVL_HIGH : (p < 80) ? tlps_pkg::LVL_MID : tlps_pkg::LVL_LOW;
    endfunction

    // random traffic: mostly level runs long enough to settle, some noise and short runs
    task automatic run_phase(input int beats);
        int               queued;
        int               len;
        int               settle;
        tlps_pkg::level_t sc;
        tlps_pkg::level_t tc;
        queued = 0;
        settle = count_load(deb_cfg);
        while (queued < beats)
        begin
            if ($urandom_range(99) < 15)
            begin
                // noise burst
                len = $urandom_range(1, 4);
                repeat (len) sensor_q.push_back(sensors_t'($urandom_range(15)));
            end
            else
            begin
                sc = pick_sump();
                tc = pick_tank();
                if ($urandom_range(99) < 10)
                begin
                    len = $urandom_range(1, settle);
                end
                else
                begin
                    len = settle + 1 + $urandom_range(0, settle + 6);
                end
                repeat (len)
                begin
                    if ($urandom_range(99) < 5)
                    begin
                        sensor_q.push_back(sensors_t'($urandom_range(15)));
                    end
                    else
                    begin
                        sensor_q.push_back(sensors_for(sc, tc));
                    end
                end
            end
            queued = queued + len;
        end
    endtask

    // hold off until every beat is sent and every result has come back
    task automatic drain();
        while (sensor_q.size() != 0 || in_valid || reading_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == tlps_pkg::CFG_DEBOUNCE_TICKS)
        begin
            deb_cfg = val;
        end
        else if (idx == tlps_pkg::CFG_START_TICKS)
        begin
            start_cfg = val;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus sequence
    initial
    begin
        model_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // every sensor combination, then a low tank over a full sump to start the motor
        for (int k = 0; k < 16; k++)
        begin
            sensor_q.push_back(sensors_t'(k[3:0]));
        end
        repeat (8) sensor_q.push_back(sensors_for(tlps_pkg::LVL_HIGH, tlps_pkg::LVL_LOW));
        drain();

        run_phase(300);
        drain();

        // shortest timers, no idling on either side
        write_reg(tlps_pkg::CFG_DEBOUNCE_TICKS, 8'd1);
        write_reg(tlps_pkg::CFG_START_TICKS, 8'd1);
        calm <= 1'b1;
        run_phase(300);
        drain();
        calm <= 1'b0;

        // zero registers act as one
        write_reg(tlps_pkg::CFG_DEBOUNCE_TICKS, 8'd0);
        write_reg(tlps_pkg::CFG_START_TICKS, 8'd0);
        run_phase(250);
        drain();

        // longest timers
        write_reg(tlps_pkg::CFG_DEBOUNCE_TICKS, 8'hFF);
        write_reg(tlps_pkg::CFG_START_TICKS, 8'hFF);
        run_phase(700);
        drain();

        // writes to unused indexes, then mid values
        write_reg(CFG_SPARE_HI, 8'h00);
        write_reg(CFG_SPARE_LO, 8'hFF);
        write_reg(tlps_pkg::CFG_DEBOUNCE_TICKS, 8'd7);
        write_reg(tlps_pkg::CFG_START_TICKS, 8'd12);
        run_phase(280);
        drain();

        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[tank_level_pump_starter] OK");
        end
        else
        begin
            $display("[tank_level_pump_starter] ERROR");
        end
        $finish;
    end

    // sensor driver: predict on accept, then present the next beat or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                reading_q.push_back(pump_step({tank_high_wet, tank_low_wet,
                                               sump_high_wet, sump_low_wet}));
            end
            if (!in_valid || !in_stall)
            begin
                if (sensor_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_beat = sensor_q.pop_front();
                    tank_high_wet <= next_beat.tank_hi;
                    tank_low_wet  <= next_beat.tank_lo;
                    sump_high_wet <= next_beat.sump_hi;
                    sump_low_wet  <= next_beat.sump_lo;
                    in_valid      <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input logic [1:0] got);
        if (got !== want[1:0])
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result monitor with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (reading_q.size() == 0)
                begin
                    $error("result beat with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    want_reading = reading_q.pop_front();
                    got_reading  = {start_coil, run_coil, sump_level, tank_level};
                    check_field("start_coil", want_reading.start_coil,
                                {1'b0, got_reading.start_coil});
                    check_field("run_coil", want_reading.run_coil,
                                {1'b0, got_reading.run_coil});
                    check_field("sump_level", want_reading.sump_level, sump_level);
                    check_field("tank_level", want_reading.tank_level, tank_level);
                end
            end
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[tank_level_pump_starter] ERROR");
            $finish;
        end
    end

endmodule
